// ----- src/mme_pkg.sv -----
// Shared types and constants for the modulation matrix evaluator.
// Used by mme_route_ram and modulation_matrix_evaluator; no dependencies.
package mme_pkg;

    localparam int ONE_Q14     = 16384;
    localparam int APB_ADDR_W  = 3;

    localparam logic [3:0] NUM_SOURCES = 4'd10;
    localparam logic [3:0] NUM_DESTS   = 4'd13;
    localparam logic [3:0] LAST_DEST   = 4'd12;
    localparam logic [3:0] LFO_FIRST   = 4'd2;
    localparam logic [3:0] LFO_LAST    = 4'd5;

    localparam logic [0:0] REG_ROUTE_COUNT = 1'b0;

    localparam logic [1:0] CMD_WRITE_ROUTE  = 2'd0;
    localparam logic [1:0] CMD_WRITE_SOURCE = 2'd1;
    localparam logic [1:0] CMD_EVALUATE     = 2'd2;

    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_SQUARE = 2'd1;
    localparam logic [1:0] CURVE_SMOOTH = 2'd2;

    typedef struct packed {
        logic [3:0]         src;
        logic [3:0]         dst;
        logic [1:0]         curve;
        logic signed [15:0] amount;
    } route_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_FETCH,
        S_LOAD,
        S_SQ,
        S_SQ_R,
        S_SS1,
        S_SS2,
        S_SS3,
        S_TERM,
        S_ACC,
        S_EMIT
    } state_t;

endpackage

// ----- src/modulation_matrix_evaluator.sv -----
// Modulation matrix evaluator, Q1.14, one shared 32x18 multiplier under a sequencer.
// Writes are taken while idle. Evaluate: CLEAR, then per route FETCH, LOAD; a skipped
// route stops there, else shaping (square: SQ, SQ_R; smoothstep: SS1-SS3), TERM, ACC.
// A last FETCH ends the walk, then 13 results at one per cycle as the sink takes them.
// Input is held off from evaluate until the last result is in the output register.
// Synchronous active-low reset: routes disabled, sources zero, route_count zero.
module modulation_matrix_evaluator #(
    parameter int ROUTE_SLOTS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_command,
    input  logic [3:0]                     s_route_index,
    input  logic [3:0]                     s_source_select,
    input  logic [3:0]                     s_destination_select,
    input  logic [1:0]                     s_curve_kind,
    input  logic signed [15:0]             s_route_amount,
    input  logic                           s_route_enabled,
    input  logic signed [15:0]             s_source_level,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [3:0]                     m_destination_index,
    output logic signed [15:0]             m_destination_level,
    output logic                           m_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mme_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int AW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
    localparam int CW = $clog2(ROUTE_SLOTS + 1);

    mme_pkg::state_t state_reg, state_next;

    logic [4:0]         route_count_reg;
    logic [CW-1:0]      route_idx_reg;
    logic [CW-1:0]      route_lim_reg;
    logic signed [15:0] src_store_reg [10];
    logic signed [15:0] sums_reg [13];
    logic signed [15:0] x_reg;
    logic signed [15:0] sh_reg;
    logic signed [15:0] amt_reg;
    logic [15:0]        w_reg;
    logic [16:0]        coef_reg;
    logic [3:0]         dst_reg;
    logic               bip_reg;
    logic signed [49:0] prod_reg;
    logic [3:0]         emit_idx_reg;
    logic               m_valid_reg;
    logic [3:0]         m_index_reg;
    logic signed [15:0] m_level_reg;
    logic               m_last_reg;

    logic               s_accept;
    logic               route_wr;
    mme_pkg::route_t    wr_route;
    mme_pkg::route_t    rd_route;
    logic               rd_enabled;
    logic               route_ok;
    logic               walk_done;
    logic               out_load;
    logic signed [31:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [15:0] src_val;
    logic               bip_c;
    logic signed [15:0] x_c;
    logic signed [16:0] v_c;
    logic [15:0]        mag;
    logic signed [49:0] rnd14;
    logic signed [49:0] rnd28;
    logic signed [49:0] rnd30;
    logic signed [16:0] ss_bip;
    logic signed [16:0] term;
    logic signed [17:0] acc_sum;
    logic [3:0]         sum_rd_addr;
    logic signed [15:0] sum_rd;
    logic               cfg_wr;

    function automatic logic signed [15:0] clamp_bip(input logic signed [15:0] v);
        if (v > 16'sd16384) begin
            return 16'sd16384;
        end else if (v < -16'sd16384) begin
            return -16'sd16384;
        end
        return v;
    endfunction

    function automatic logic signed [15:0] clamp_uni(input logic signed [15:0] v);
        if (v > 16'sd16384) begin
            return 16'sd16384;
        end else if (v < 16'sd0) begin
            return 16'sd0;
        end
        return v;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[mme_pkg::APB_ADDR_W-1:2] == mme_pkg::REG_ROUTE_COUNT) begin
            prdata = {27'd0, route_count_reg};
        end
    end

    // route table
    assign s_accept = s_valid && s_ready;
    assign route_wr = s_accept && (s_command == mme_pkg::CMD_WRITE_ROUTE)
                      && (32'(s_route_index) < ROUTE_SLOTS);
    assign wr_route = '{src: s_source_select, dst: s_destination_select,
                        curve: s_curve_kind, amount: s_route_amount};

    mme_route_ram #(
        .ROUTE_SLOTS (ROUTE_SLOTS),
        .AW          (AW)
    ) u_route_ram (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (route_wr),
        .wr_addr    (AW'(s_route_index)),
        .wr_route   (wr_route),
        .wr_enabled (s_route_enabled),
        .rd_addr    (route_idx_reg[AW-1:0]),
        .rd_route   (rd_route),
        .rd_enabled (rd_enabled)
    );

    // route decode and source shaping inputs
    assign route_ok  = rd_enabled && (rd_route.src < mme_pkg::NUM_SOURCES)
                       && (rd_route.dst < mme_pkg::NUM_DESTS);
    assign walk_done = (route_idx_reg >= route_lim_reg);

    always_comb begin
        src_val = 16'sd0;
        if (rd_route.src < mme_pkg::NUM_SOURCES) begin
            src_val = src_store_reg[rd_route.src];
        end
        bip_c = (rd_route.src >= mme_pkg::LFO_FIRST) && (rd_route.src <= mme_pkg::LFO_LAST);
        x_c   = bip_c ? clamp_bip(src_val) : clamp_uni(src_val);
        v_c   = 17'(x_c) + 17'sd16384;
        mag   = x_reg[15] ? 16'(-x_reg) : 16'(x_reg);
    end

    // rounding, ties toward plus infinity
    assign rnd14   = prod_reg + 50'sd8192;
    assign rnd28   = prod_reg + 50'sd134217728;
    assign rnd30   = prod_reg + 50'sd536870912;
    assign ss_bip  = $signed(rnd30[46:30]) - 17'sd16384;
    assign term    = $signed(rnd14[30:14]);
    assign sum_rd  = sums_reg[sum_rd_addr];
    assign acc_sum = 18'(sum_rd) + 18'(term);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mme_pkg::S_IDLE: begin
                if (s_valid && s_command == mme_pkg::CMD_EVALUATE) begin
                    state_next = mme_pkg::S_CLEAR;
                end
            end
            mme_pkg::S_CLEAR: state_next = mme_pkg::S_FETCH;
            mme_pkg::S_FETCH: begin
                state_next = walk_done ? mme_pkg::S_EMIT : mme_pkg::S_LOAD;
            end
            mme_pkg::S_LOAD: begin
                if (!route_ok) begin
                    state_next = mme_pkg::S_FETCH;
                end else begin
                    case (rd_route.curve)
                        mme_pkg::CURVE_SQUARE: state_next = mme_pkg::S_SQ;
                        mme_pkg::CURVE_SMOOTH: state_next = mme_pkg::S_SS1;
                        default:               state_next = mme_pkg::S_TERM;
                    endcase
                end
            end
            mme_pkg::S_SQ:   state_next = mme_pkg::S_SQ_R;
            mme_pkg::S_SQ_R: state_next = mme_pkg::S_TERM;
            mme_pkg::S_SS1:  state_next = mme_pkg::S_SS2;
            mme_pkg::S_SS2:  state_next = mme_pkg::S_SS3;
            mme_pkg::S_SS3:  state_next = mme_pkg::S_TERM;
            mme_pkg::S_TERM: state_next = mme_pkg::S_ACC;
            mme_pkg::S_ACC:  state_next = mme_pkg::S_FETCH;
            mme_pkg::S_EMIT: begin
                if (out_load && emit_idx_reg == mme_pkg::LAST_DEST) begin
                    state_next = mme_pkg::S_IDLE;
                end
            end
            default: state_next = mme_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: handshake, multiplier operands, sum read port
    always_comb begin
        s_ready     = 1'b0;
        out_load    = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        sum_rd_addr = dst_reg;
        unique case (state_reg)
            mme_pkg::S_IDLE: s_ready = 1'b1;
            mme_pkg::S_SQ: begin
                mul_a = 32'(mag);
                mul_b = 18'(mag);
            end
            mme_pkg::S_SS1: begin
                mul_a = 32'(w_reg);
                mul_b = 18'(w_reg);
            end
            mme_pkg::S_SS2: begin
                mul_a = prod_reg[31:0];
                mul_b = 18'(coef_reg);
            end
            mme_pkg::S_TERM: begin
                mul_a = 32'(sh_reg);
                mul_b = 18'(amt_reg);
            end
            mme_pkg::S_EMIT: begin
                out_load    = !m_valid_reg || m_ready;
                sum_rd_addr = emit_idx_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mme_pkg::S_IDLE;
            route_count_reg <= '0;
            route_idx_reg   <= '0;
            route_lim_reg   <= '0;
            emit_idx_reg    <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < 10; i++) begin
                src_store_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr && paddr[mme_pkg::APB_ADDR_W-1:2] == mme_pkg::REG_ROUTE_COUNT) begin
                route_count_reg <= pwdata[4:0];
            end
            if (s_accept && s_command == mme_pkg::CMD_WRITE_SOURCE
                    && s_source_select < mme_pkg::NUM_SOURCES) begin
                src_store_reg[s_source_select] <= s_source_level;
            end
            if (state_reg == mme_pkg::S_CLEAR) begin
                route_idx_reg <= '0;
                emit_idx_reg  <= '0;
                if (32'(route_count_reg) < ROUTE_SLOTS) begin
                    route_lim_reg <= CW'(route_count_reg);
                end else begin
                    route_lim_reg <= CW'(ROUTE_SLOTS);
                end
            end
            if ((state_reg == mme_pkg::S_LOAD && !route_ok) || state_reg == mme_pkg::S_ACC) begin
                route_idx_reg <= route_idx_reg + 1'b1;
            end
            if (out_load) begin
                emit_idx_reg <= emit_idx_reg + 1'b1;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            mme_pkg::S_CLEAR: begin
                for (int i = 0; i < 13; i++) begin
                    sums_reg[i] <= '0;
                end
            end
            mme_pkg::S_LOAD: begin
                x_reg     <= x_c;
                bip_reg   <= bip_c;
                w_reg     <= bip_c ? v_c[15:0] : 16'(x_c);
                dst_reg   <= rd_route.dst;
                amt_reg   <= clamp_bip(rd_route.amount);
                sh_reg    <= (rd_route.curve == mme_pkg::CURVE_LINEAR) ? x_c : 16'sd0;
            end
            mme_pkg::S_SQ_R: begin
                sh_reg <= x_reg[15] ? -$signed(rnd14[29:14]) : $signed(rnd14[29:14]);
            end
            mme_pkg::S_SS1: begin
                coef_reg <= bip_reg ? 17'(18'd98304 - {1'b0, w_reg, 1'b0})
                                    : 17'(18'd49152 - {1'b0, w_reg, 1'b0});
            end
            mme_pkg::S_SS3: begin
                sh_reg <= bip_reg ? ss_bip[15:0] : $signed(rnd28[43:28]);
            end
            mme_pkg::S_ACC: begin
                if (acc_sum > 18'sd16384) begin
                    sums_reg[dst_reg] <= 16'sd16384;
                end else if (acc_sum < -18'sd16384) begin
                    sums_reg[dst_reg] <= -16'sd16384;
                end else begin
                    sums_reg[dst_reg] <= acc_sum[15:0];
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_index_reg <= emit_idx_reg;
            m_level_reg <= sum_rd;
            m_last_reg  <= (emit_idx_reg == mme_pkg::LAST_DEST);
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_destination_index = m_index_reg;
    assign m_destination_level = m_level_reg;
    assign m_last              = m_last_reg;

`ifndef NO_ASSERTIONS
    a_route_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(route_idx_reg) <= ROUTE_SLOTS)
        else $error("route walk ran past the table");

    a_eval_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == mme_pkg::CMD_EVALUATE |=> state_reg == mme_pkg::S_CLEAR)
        else $error("evaluate request did not start a walk");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_destination_index == mme_pkg::LAST_DEST)
        else $error("last flag on wrong destination");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_destination_level <= 16'sd16384 && m_destination_level >= -16'sd16384))
        else $error("destination level out of range");

    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mme_pkg::S_EMIT && out_load && emit_idx_reg == mme_pkg::LAST_DEST
        |=> state_reg == mme_pkg::S_IDLE && m_valid && m_last)
        else $error("evaluation did not finish on the last destination");
`endif

endmodule

// ----- src/mme_route_ram.sv -----
// Route table: one write port, one registered read port, enable flags in flops.
// Depends on mme_pkg (route_t).
module mme_route_ram #(
    parameter int ROUTE_SLOTS = 16,
    parameter int AW          = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  mme_pkg::route_t wr_route,
    input  logic            wr_enabled,
    input  logic [AW-1:0]   rd_addr,
    output mme_pkg::route_t rd_route,
    output logic            rd_enabled
);

    mme_pkg::route_t mem [ROUTE_SLOTS];
    logic [ROUTE_SLOTS-1:0] en_reg;
    mme_pkg::route_t rd_route_reg;
    logic rd_enabled_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_route;
        end
        rd_route_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg         <= '0;
            rd_enabled_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                en_reg[wr_addr] <= wr_enabled;
            end
            rd_enabled_reg <= en_reg[rd_addr];
        end
    end

    assign rd_route   = rd_route_reg;
    assign rd_enabled = rd_enabled_reg;

endmodule

// ----- tb/modulation_matrix_evaluator_test.sv -----
// Self-checking testbench for modulation_matrix_evaluator: random valid/ready traffic,
// APB writes of route_count and an in-bench predictor of the 13 destination sums.
// Depends on mme_pkg and the modulation_matrix_evaluator RTL only.
`timescale 1ns / 1ps

module modulation_matrix_evaluator_test;

    localparam int ROUTE_SLOTS = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ADDR_W = mme_pkg::APB_ADDR_W;
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam logic [1:0] CURVE_NONE = 2'd3;

    typedef struct {
        logic [1:0]         command;
        logic [3:0]         route_index;
        logic [3:0]         source_select;
        logic [3:0]         destination_select;
        logic [1:0]         curve_kind;
        logic signed [15:0] route_amount;
        logic               route_enabled;
        logic signed [15:0] source_level;
    } request_t;

    typedef struct {
        logic [3:0]         dest;
        logic signed [15:0] level;
        logic               is_last;
    } dest_result_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_command = '0;
    logic [3:0] s_route_index = '0;
    logic [3:0] s_source_select = '0;
    logic [3:0] s_destination_select = '0;
    logic [1:0] s_curve_kind = '0;
    logic signed [15:0] s_route_amount = '0;
    logic s_route_enabled = 1'b0;
    logic signed [15:0] s_source_level = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [3:0] m_destination_index;
    logic signed [15:0] m_destination_level;
    logic m_last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    modulation_matrix_evaluator #(
        .ROUTE_SLOTS(ROUTE_SLOTS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_route_index(s_route_index),
        .s_source_select(s_source_select),
        .s_destination_select(s_destination_select),
        .s_curve_kind(s_curve_kind),
        .s_route_amount(s_route_amount),
        .s_route_enabled(s_route_enabled),
        .s_source_level(s_source_level),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_destination_index(m_destination_index),
        .m_destination_level(m_destination_level),
        .m_last(m_last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    request_t request_queue[$];
    dest_result_t expected_levels[$];
    request_t on_port;
    bit offering = 0;
    int failures = 0;
    int send_idle_pct = 37;
    int recv_idle_pct = 85;
    bit hold_request = 0;
    int hold_count = 0;

    // matrix state as the block should hold it
    mme_pkg::route_t routes_model[ROUTE_SLOTS];
    bit route_on[ROUTE_SLOTS];
    int source_model[10];
    int route_count_model = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #7_200_000;
        $display("CHECK FAILED");
        $finish;
    end

    // round to nearest, ties towards plus infinity
    function automatic longint round_div_pow2(longint p, int sh);
        return (p + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic int clamp_q14(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int shape_source(int raw, logic [1:0] curve, bit bipolar);
        int x;
        longint m;
        longint sq;
        x = bipolar ? clamp_q14(raw, -mme_pkg::ONE_Q14, mme_pkg::ONE_Q14)
                    : clamp_q14(raw, 0, mme_pkg::ONE_Q14);
        case (curve)
            mme_pkg::CURVE_LINEAR: return x;
            mme_pkg::CURVE_SQUARE: begin
                m = x < 0 ? -longint'(x) : longint'(x);
                sq = round_div_pow2(m * m, 14);
                return x < 0 ? -int'(sq) : int'(sq);
            end
            mme_pkg::CURVE_SMOOTH: begin
                if (bipolar) begin
                    m = longint'(x) + mme_pkg::ONE_Q14;
                    return int'(round_div_pow2(m * m * (98304 - 2 * m), 30)) - mme_pkg::ONE_Q14;
                end
                m = x;
                return int'(round_div_pow2(m * m * (49152 - 2 * m), 28));
            end
            default: return 0;
        endcase
    endfunction

    function automatic void apply_to_matrix(request_t r);
        int sums[13];
        int n;
        int sh;
        int amt;
        longint term;
        dest_result_t res;
        case (r.command)
            mme_pkg::CMD_WRITE_ROUTE: begin
                if (r.route_index < ROUTE_SLOTS) begin
                    routes_model[r.route_index].src = r.source_select;
                    routes_model[r.route_index].dst = r.destination_select;
                    routes_model[r.route_index].curve = r.curve_kind;
                    routes_model[r.route_index].amount = r.route_amount;
                    route_on[r.route_index] = r.route_enabled;
                end
            end
            mme_pkg::CMD_WRITE_SOURCE: begin
                if (r.source_select < mme_pkg::NUM_SOURCES)
                    source_model[r.source_select] = r.source_level;
            end
            mme_pkg::CMD_EVALUATE: begin
                foreach (sums[d])
                    sums[d] = 0;
                n = route_count_model < ROUTE_SLOTS ? route_count_model : ROUTE_SLOTS;
                for (int i = 0; i < n; i++) begin
                    if (!route_on[i] || routes_model[i].src >= mme_pkg::NUM_SOURCES
                            || routes_model[i].dst >= mme_pkg::NUM_DESTS)
                        continue;
                    sh = shape_source(source_model[routes_model[i].src], routes_model[i].curve,
                                      routes_model[i].src >= mme_pkg::LFO_FIRST
                                      && routes_model[i].src <= mme_pkg::LFO_LAST);
                    amt = clamp_q14(routes_model[i].amount, -mme_pkg::ONE_Q14,
                                    mme_pkg::ONE_Q14);
                    term = round_div_pow2(longint'(sh) * longint'(amt), 14);
                    sums[routes_model[i].dst] =
                        clamp_q14(sums[routes_model[i].dst] + int'(term),
                                  -mme_pkg::ONE_Q14, mme_pkg::ONE_Q14);
                end
                for (int d = 0; d < mme_pkg::NUM_DESTS; d++) begin
                    res.dest = 4'(d);
                    res.level = 16'(sums[d]);
                    res.is_last = (d == mme_pkg::LAST_DEST);
                    expected_levels.push_back(res);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [15:0] random_amount();
        case ($urandom_range(9))
            0: return 16'(mme_pkg::ONE_Q14);
            1: return 16'(-mme_pkg::ONE_Q14);
            2, 3: return 16'($urandom);
            4: return 16'sd0;
            default: return 16'($urandom_range(2 * mme_pkg::ONE_Q14) - mme_pkg::ONE_Q14);
        endcase
    endfunction

    function automatic logic signed [15:0] random_level();
        case ($urandom_range(11))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(mme_pkg::ONE_Q14);
            3: return 16'(-mme_pkg::ONE_Q14);
            4: return 16'sd0;
            5, 6: return 16'($urandom);
            default: return 16'($urandom_range(2 * mme_pkg::ONE_Q14) - mme_pkg::ONE_Q14);
        endcase
    endfunction

    function automatic request_t random_request(logic [1:0] cmd);
        request_t r;
        r.command = cmd;
        r.route_index = 4'($urandom_range(15));
        r.source_select = $urandom_range(9) ? 4'($urandom_range(9))
                                            : 4'($urandom_range(15, 10));
        r.destination_select = $urandom_range(12) ? 4'($urandom_range(12))
                                                  : 4'($urandom_range(15, 13));
        r.curve_kind = $urandom_range(9) ? 2'($urandom_range(2)) : CURVE_NONE;
        r.route_amount = random_amount();
        r.route_enabled = $urandom_range(99) < 85;
        r.source_level = random_level();
        return r;
    endfunction

    function automatic request_t route_write(int idx, int src, int dst, logic [1:0] curve,
                                             int amount, bit en);
        request_t r;
        r = random_request(mme_pkg::CMD_WRITE_ROUTE);
        r.route_index = 4'(idx);
        r.source_select = 4'(src);
        r.destination_select = 4'(dst);
        r.curve_kind = curve;
        r.route_amount = 16'(amount);
        r.route_enabled = en;
        return r;
    endfunction

    function automatic request_t source_write(int sel, int level);
        request_t r;
        r = random_request(mme_pkg::CMD_WRITE_SOURCE);
        r.source_select = 4'(sel);
        r.source_level = 16'(level);
        return r;
    endfunction

    task automatic queue_random(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 3)
                request_queue.push_back(random_request(CMD_NONE));
            else if (pick < 45)
                request_queue.push_back(random_request(mme_pkg::CMD_WRITE_ROUTE));
            else if (pick < 80)
                request_queue.push_back(random_request(mme_pkg::CMD_WRITE_SOURCE));
            else
                request_queue.push_back(random_request(mme_pkg::CMD_EVALUATE));
        end
    endtask

    task automatic drain();
        while (request_queue.size() != 0 || offering || expected_levels.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_route_count(int value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * mme_pkg::REG_ROUTE_COUNT);
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== 32'(value & 31) || pready !== 1'b1) begin
            $display("%0t: route_count read back, expected %0d, got %0d",
                     $time, value & 31, prdata);
            failures++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        route_count_model = value & 5'h1f;
    endtask

    // request driver
    always @(posedge aclk) begin : drive_requests
        request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_to_matrix(on_port);
                offering = 0;
            end
            if (!s_valid || s_ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = request_queue.pop_front();
                    on_port = nxt;
                    offering = 1;
                    s_valid <= 1'b1;
                    s_command <= nxt.command;
                    s_route_index <= nxt.route_index;
                    s_source_select <= nxt.source_select;
                    s_destination_select <= nxt.destination_select;
                    s_curve_kind <= nxt.curve_kind;
                    s_route_amount <= nxt.route_amount;
                    s_route_enabled <= nxt.route_enabled;
                    s_source_level <= nxt.source_level;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_count <= 0;
        end else if (hold_request) begin
            hold_count <= HOLD_OFF_CYCLES;
        end else if (hold_count != 0) begin
            hold_count <= hold_count - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin : check_results
        dest_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_levels.size() == 0) begin
                    $display("%0t: unexpected result, got dest %0d level %0d last %0b",
                             $time, m_destination_index, m_destination_level, m_last);
                    failures++;
                end else begin
                    want = expected_levels.pop_front();
                    if (m_destination_index !== want.dest || m_destination_level !== want.level
                            || m_last !== want.is_last) begin
                        $display({"%0t: mismatch, expected dest %0d level %0d last %0b, ",
                                  "got dest %0d level %0d last %0b"},
                                 $time, want.dest, want.level, want.is_last,
                                 m_destination_index, m_destination_level, m_last);
                        failures++;
                    end
                end
            end
            m_ready <= (hold_count != 0) ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        foreach (route_on[i]) begin
            route_on[i] = 0;
            routes_model[i] = '0;
        end
        foreach (source_model[i])
            source_model[i] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // sender 37 %, receiver 85 % idle
        write_route_count(ROUTE_SLOTS);
        request_queue.push_back(source_write(0, mme_pkg::ONE_Q14));
        request_queue.push_back(source_write(1, -32768));
        request_queue.push_back(source_write(2, -32768));
        request_queue.push_back(source_write(3, 32767));
        request_queue.push_back(source_write(4, -5000));
        request_queue.push_back(source_write(7, 9000));
        request_queue.push_back(source_write(13, 1234));
        request_queue.push_back(route_write(0, 0, 0, mme_pkg::CURVE_LINEAR,
                                            mme_pkg::ONE_Q14, 1));
        request_queue.push_back(route_write(1, 0, 0, mme_pkg::CURVE_LINEAR,
                                            mme_pkg::ONE_Q14, 1));
        request_queue.push_back(route_write(2, 3, 1, mme_pkg::CURVE_SQUARE,
                                            -mme_pkg::ONE_Q14, 1));
        request_queue.push_back(route_write(3, 2, 2, mme_pkg::CURVE_SMOOTH,
                                            mme_pkg::ONE_Q14, 1));
        request_queue.push_back(route_write(4, 4, 3, mme_pkg::CURVE_SQUARE, 32767, 1));
        request_queue.push_back(route_write(5, 7, 4, mme_pkg::CURVE_SMOOTH, -32768, 1));
        request_queue.push_back(route_write(6, 4, 5, mme_pkg::CURVE_SMOOTH, 8192, 1));
        request_queue.push_back(route_write(7, 7, 6, CURVE_NONE, mme_pkg::ONE_Q14, 1));
        request_queue.push_back(route_write(8, 11, 7, mme_pkg::CURVE_LINEAR,
                                            mme_pkg::ONE_Q14, 1));
        request_queue.push_back(route_write(9, 0, 14, mme_pkg::CURVE_LINEAR,
                                            mme_pkg::ONE_Q14, 1));
        request_queue.push_back(route_write(10, 1, 8, mme_pkg::CURVE_LINEAR,
                                            mme_pkg::ONE_Q14, 1));
        request_queue.push_back(route_write(11, 0, 12, mme_pkg::CURVE_LINEAR,
                                            -mme_pkg::ONE_Q14, 0));
        request_queue.push_back(route_write(12, 0, 0, mme_pkg::CURVE_LINEAR,
                                            -mme_pkg::ONE_Q14, 1));
        request_queue.push_back(random_request(mme_pkg::CMD_EVALUATE));
        request_queue.push_back(random_request(CMD_NONE));
        request_queue.push_back(random_request(mme_pkg::CMD_EVALUATE));
        queue_random(40);
        drain();

        // sender 85 %, receiver 37 % idle; route_count beyond the table, then none, then 1 to 15
        send_idle_pct = 85;
        recv_idle_pct = 37;
        write_route_count(31);
        queue_random(20);
        request_queue.push_back(random_request(mme_pkg::CMD_EVALUATE));
        drain();
        write_route_count(0);
        request_queue.push_back(random_request(mme_pkg::CMD_WRITE_ROUTE));
        request_queue.push_back(random_request(mme_pkg::CMD_EVALUATE));
        drain();
        write_route_count($urandom_range(15, 1));
        queue_random(15);
        drain();

        // no idling, with one long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_route_count($urandom_range(ROUTE_SLOTS, 1));
        @(posedge aclk);
        hold_request <= 1'b1;
        @(posedge aclk);
        hold_request <= 1'b0;
        request_queue.push_back(random_request(mme_pkg::CMD_EVALUATE));
        queue_random(15);
        request_queue.push_back(random_request(mme_pkg::CMD_EVALUATE));
        queue_random(15);
        drain();

        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/mme_pkg.sv
src/mme_route_ram.sv
src/modulation_matrix_evaluator.sv
tb/modulation_matrix_evaluator_test.sv
